>>> sv/tsg_pkg.sv
// Shared constants and controller/datapath interface types for the span generator.
`timescale 1ns / 1ps

package tsg_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int NUM_W   = COORD_BITS + FRAC_BITS;
	localparam int SLOPE_W = NUM_W + 1;
	localparam int ACC_W   = COORD_BITS + FRAC_BITS + 2;
	localparam int CNT_W   = $clog2(NUM_W + 1);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SPAN = 1'b1;

	typedef enum logic [1:0] {
		DIV_SHORT,
		DIV_LONG,
		DIV_TAIL
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		logic     span;
		div_sel_t div_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic active;
	} dp_sts_t;

endpackage

>>> sv/triangle_scanline_span_generator.sv
// Top level of the triangle scanline span generator.
// A load item (operation 0) sorts the vertices by y and computes the short, long and
// tail edge slopes in turn on one shared bit-serial divider; no item is accepted until
// all of them are done. A step item (operation 1) yields one span, or nothing when no
// triangle is active; a pending unaccepted span holds it until the output side takes
// the earlier item. Row y1 is emitted twice, and the final span of the triangle carries
// span_last.
`timescale 1ns / 1ps

module triangle_scanline_span_generator import tsg_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic signed [COORD_BITS-1:0] vertex_a_x,
	input  logic signed [COORD_BITS-1:0] vertex_a_y,
	input  logic signed [COORD_BITS-1:0] vertex_b_x,
	input  logic signed [COORD_BITS-1:0] vertex_b_y,
	input  logic signed [COORD_BITS-1:0] vertex_c_x,
	input  logic signed [COORD_BITS-1:0] vertex_c_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] row_y,
	output logic signed [COORD_BITS-1:0] span_start_x,
	output logic signed [COORD_BITS-1:0] span_end_x,
	output logic                         span_last
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tsg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tsg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.vertex_a_x   (vertex_a_x),
		.vertex_a_y   (vertex_a_y),
		.vertex_b_x   (vertex_b_x),
		.vertex_b_y   (vertex_b_y),
		.vertex_c_x   (vertex_c_x),
		.vertex_c_y   (vertex_c_y),
		.row_y        (row_y),
		.span_start_x (span_start_x),
		.span_end_x   (span_end_x),
		.span_last    (span_last)
	);

endmodule

>>> sv/tsg_div.sv
// Restoring divider for edge slopes, one quotient bit per cycle.
`timescale 1ns / 1ps

module tsg_div import tsg_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [DIFF_W-1:0]  dx,
	input  logic signed [DIFF_W-1:0]  dy,
	output logic                      done,
	output logic signed [SLOPE_W-1:0] quotient
);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [NUM_W-1:0]      num_q;
	logic [COORD_BITS-1:0] rem_q;
	logic [COORD_BITS-1:0] den_q;
	logic                  neg_q;
	logic                  zero_q;

	logic [DIFF_W-1:0]     dx_mag;
	logic [COORD_BITS:0]   rem_sh;
	logic [COORD_BITS:0]   rem_nx;
	logic                  fits;
	logic [SLOPE_W-1:0]    mag_ext;

	always_comb begin
		dx_mag  = dx[DIFF_W-1] ? -dx : dx;
		rem_sh  = {rem_q, num_q[NUM_W-1]};
		fits    = rem_sh >= {1'b0, den_q};
		rem_nx  = fits ? rem_sh - {1'b0, den_q} : rem_sh;
		mag_ext = {1'b0, num_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= cnt_q == CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {dx_mag[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			den_q  <= dy[COORD_BITS-1:0];
			neg_q  <= dx[DIFF_W-1];
			zero_q <= dy[DIFF_W-1] || (dy == '0);
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= rem_nx[COORD_BITS-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? '0 : (neg_q ? -mag_ext : mag_ext);

endmodule

>>> sv/tsg_datapath.sv
// Vertex sort, slope and accumulator registers, and the span output register.
`timescale 1ns / 1ps

module tsg_datapath import tsg_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	output dp_sts_t                      sts,
	input  logic signed [COORD_BITS-1:0] vertex_a_x,
	input  logic signed [COORD_BITS-1:0] vertex_a_y,
	input  logic signed [COORD_BITS-1:0] vertex_b_x,
	input  logic signed [COORD_BITS-1:0] vertex_b_y,
	input  logic signed [COORD_BITS-1:0] vertex_c_x,
	input  logic signed [COORD_BITS-1:0] vertex_c_y,
	output logic signed [COORD_BITS-1:0] row_y,
	output logic signed [COORD_BITS-1:0] span_start_x,
	output logic signed [COORD_BITS-1:0] span_end_x,
	output logic                         span_last
);

	logic signed [COORD_BITS-1:0] vx_q [3];
	logic signed [COORD_BITS-1:0] vy_q [3];
	logic signed [SLOPE_W-1:0]    short_q;
	logic signed [SLOPE_W-1:0]    long_q;
	logic signed [SLOPE_W-1:0]    tail_q;
	logic signed [ACC_W-1:0]      start_acc_q;
	logic signed [ACC_W-1:0]      end_acc_q;
	logic signed [COORD_BITS-1:0] row_q;
	logic                         lower_q;
	logic                         active_q;

	logic signed [COORD_BITS-1:0] row_y_q;
	logic signed [COORD_BITS-1:0] start_x_q;
	logic signed [COORD_BITS-1:0] end_x_q;
	logic                         last_q;

	logic signed [COORD_BITS-1:0] sx [3];
	logic signed [COORD_BITS-1:0] sy [3];
	logic signed [DIFF_W-1:0]     div_dx;
	logic signed [DIFF_W-1:0]     div_dy;
	logic                         div_done;
	logic signed [SLOPE_W-1:0]    div_q;
	logic                         at_mid;
	logic                         at_end;
	logic signed [ACC_W-1:0]      short_ext;
	logic signed [ACC_W-1:0]      long_ext;

	function automatic logic signed [ACC_W-1:0] to_fixed(input logic signed [COORD_BITS-1:0] x);
		return {{2{x[COORD_BITS-1]}}, x, {FRAC_BITS{1'b0}}};
	endfunction

	function automatic logic signed [DIFF_W-1:0] diff(input logic signed [COORD_BITS-1:0] a,
			input logic signed [COORD_BITS-1:0] b);
		return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
	endfunction

	// Integer part truncated toward zero, wrapped to the coordinate width.
	function automatic logic signed [COORD_BITS-1:0] trunc_fixed(input logic signed [ACC_W-1:0] a);
		logic [ACC_W-1:0] ip;
		ip = a >>> FRAC_BITS;
		if (a[ACC_W-1] && (a[FRAC_BITS-1:0] != '0)) begin
			ip = ip + 1'b1;
		end
		return ip[COORD_BITS-1:0];
	endfunction

	// Three compare-and-swap steps: (a,b), (b,c), (a,b).
	always_comb begin
		logic signed [COORD_BITS-1:0] tx;
		logic signed [COORD_BITS-1:0] ty;
		tx = '0;
		ty = '0;
		sx[0] = vertex_a_x;
		sy[0] = vertex_a_y;
		sx[1] = vertex_b_x;
		sy[1] = vertex_b_y;
		sx[2] = vertex_c_x;
		sy[2] = vertex_c_y;
		if (sy[0] > sy[1]) begin
			tx = sx[0]; ty = sy[0];
			sx[0] = sx[1]; sy[0] = sy[1];
			sx[1] = tx; sy[1] = ty;
		end
		if (sy[1] > sy[2]) begin
			tx = sx[1]; ty = sy[1];
			sx[1] = sx[2]; sy[1] = sy[2];
			sx[2] = tx; sy[2] = ty;
		end
		if (sy[0] > sy[1]) begin
			tx = sx[0]; ty = sy[0];
			sx[0] = sx[1]; sy[0] = sy[1];
			sx[1] = tx; sy[1] = ty;
		end
	end

	always_comb begin
		case (cmd.div_sel)
			DIV_SHORT: begin
				div_dx = diff(vx_q[1], vx_q[0]);
				div_dy = diff(vy_q[1], vy_q[0]);
			end
			DIV_LONG: begin
				div_dx = diff(vx_q[2], vx_q[0]);
				div_dy = diff(vy_q[2], vy_q[0]);
			end
			default: begin
				div_dx = diff(vx_q[2], vx_q[1]);
				div_dy = diff(vy_q[2], vy_q[1]);
			end
		endcase
	end

	tsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dx       (div_dx),
		.dy       (div_dy),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		at_mid    = row_q >= vy_q[1];
		at_end    = row_q >= vy_q[2];
		short_ext = {{(ACC_W - SLOPE_W){short_q[SLOPE_W-1]}}, short_q};
		long_ext  = {{(ACC_W - SLOPE_W){long_q[SLOPE_W-1]}}, long_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q  <= 1'b0;
			active_q <= 1'b0;
		end else if (cmd.load) begin
			lower_q  <= 1'b0;
			active_q <= 1'b1;
		end else if (cmd.span) begin
			if (!lower_q) begin
				if (at_mid) begin
					lower_q <= 1'b1;
				end
			end else if (at_end) begin
				active_q <= 1'b0;
			end
		end
	end

	// At the middle vertex the long-edge accumulator already holds
	// x0 + long_slope * (y1 - y0), so only the short edge restarts.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= sx[i];
				vy_q[i] <= sy[i];
			end
			start_acc_q <= to_fixed(sx[0]);
			end_acc_q   <= to_fixed(sx[0]);
			row_q       <= sy[0];
		end else if (div_done) begin
			case (cmd.div_sel)
				DIV_SHORT: short_q <= div_q;
				DIV_LONG:  long_q  <= div_q;
				default:   tail_q  <= div_q;
			endcase
		end else if (cmd.span) begin
			row_y_q   <= row_q;
			start_x_q <= trunc_fixed(start_acc_q);
			end_x_q   <= trunc_fixed(end_acc_q);
			last_q    <= lower_q && at_end;
			if (!lower_q && at_mid) begin
				row_q       <= vy_q[1];
				start_acc_q <= to_fixed(vx_q[1]);
				if (vy_q[2] > vy_q[1]) begin
					short_q <= tail_q;
				end
			end else if (!(lower_q && at_end)) begin
				row_q       <= row_q + 1'b1;
				start_acc_q <= start_acc_q + short_ext;
				end_acc_q   <= end_acc_q + long_ext;
			end
		end
	end

	assign sts.div_done = div_done;
	assign sts.active   = active_q;

	assign row_y        = row_y_q;
	assign span_start_x = start_x_q;
	assign span_end_x   = end_x_q;
	assign span_last    = last_q;

endmodule

>>> sv/tsg_ctrl.sv
// Controller state machine: item handshake, slope division sequence and output valid.
`timescale 1ns / 1ps

module tsg_ctrl import tsg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    operation,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_SPAN
	} state_t;

	state_t   state_q;
	div_sel_t sel_q;
	logic     out_valid_q;
	logic     slot_free;

	always_comb begin
		slot_free     = !out_valid_q || out_ready;
		cmd.load      = (state_q == S_IDLE) && in_valid && (operation == OP_LOAD);
		cmd.div_start = state_q == S_DIV_GO;
		cmd.span      = (state_q == S_SPAN) && sts.active && slot_free;
		cmd.div_sel   = sel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= DIV_SHORT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.span) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (operation)
							OP_LOAD: begin
								state_q <= S_DIV_GO;
								sel_q   <= DIV_SHORT;
							end
							OP_SPAN: state_q <= S_SPAN;
						endcase
					end
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (sts.div_done) begin
						unique case (sel_q)
							DIV_SHORT: begin
								sel_q   <= DIV_LONG;
								state_q <= S_DIV_GO;
							end
							DIV_LONG: begin
								sel_q   <= DIV_TAIL;
								state_q <= S_DIV_GO;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SPAN: begin
					if (!sts.active || slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_span_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.span |-> (!out_valid_q || out_ready))
		else $error("span written over an item not yet taken");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_DIV_WAIT))
		else $error("divider finished outside the wait state");

	a_load_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (operation == OP_LOAD)) |=>
		(state_q == S_DIV_GO && sel_q == DIV_SHORT))
		else $error("load item did not start the slope sequence");

	a_span_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.span |=> out_valid_q)
		else $error("span produced without output valid");
`endif

endmodule

>>> tb/triangle_scanline_span_generator_tb.sv
// Self-checking testbench for the span generator: directed table, then random triangles.
`timescale 1ns / 1ps

module triangle_scanline_span_generator_tb import tsg_pkg::*;;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t row;
		coord_t start_x;
		coord_t end_x;
		logic   last;
	} span_t;

	typedef struct {
		logic   op;
		coord_t ax, ay, bx, by, cx, cy;
		bit     typed;
		span_t  want;
	} stim_row_t;

	localparam int ITEM_GOAL   = 1650;
	localparam int QUIET_FROM  = 1450;
	localparam int HOLD_AT     = 200;
	localparam int HOLD_CYCLES = 600;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN       = 200;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	logic   operation = OP_LOAD;
	coord_t vertex_a_x = '0;
	coord_t vertex_a_y = '0;
	coord_t vertex_b_x = '0;
	coord_t vertex_b_y = '0;
	coord_t vertex_c_x = '0;
	coord_t vertex_c_y = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	coord_t row_y;
	coord_t span_start_x;
	coord_t span_end_x;
	logic   span_last;

	// Rasterizer state kept by the testbench.
	longint sorted_x [3];
	longint sorted_y [3];
	longint short_step;
	longint long_step;
	longint start_acc;
	longint end_acc;
	longint scan_row;
	bit     in_lower;
	bit     busy;

	span_t  spans_due [$];
	span_t  expected_span;
	int     items_done;
	int     errors;
	int     idle_cycles;
	int     stall_left;
	int     hold_left;
	bit     hold_done;

	triangle_scanline_span_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.vertex_a_x(vertex_a_x),
		.vertex_a_y(vertex_a_y),
		.vertex_b_x(vertex_b_x),
		.vertex_b_y(vertex_b_y),
		.vertex_c_x(vertex_c_x),
		.vertex_c_y(vertex_c_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.row_y(row_y),
		.span_start_x(span_start_x),
		.span_end_x(span_end_x),
		.span_last(span_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic coord_t to_coord(input longint v);
		return v[COORD_BITS-1:0];
	endfunction

	function automatic coord_t rand_coord();
		int r;
		r = $urandom;
		return r[COORD_BITS-1:0];
	endfunction

	function automatic logic rand_bit();
		int r;
		r = $urandom;
		return r[0];
	endfunction

	function automatic bit idling_allowed();
		return items_done < QUIET_FROM && !(items_done >= 600 && items_done < 900);
	endfunction

	function automatic longint edge_slope(input longint dx, input longint dy);
		if (dy <= 0)
			return 0;
		return (dx * (longint'(1) << FRAC_BITS)) / dy;
	endfunction

	task automatic swap_sorted(input int i, input int j);
		longint t;
		t = sorted_x[i];
		sorted_x[i] = sorted_x[j];
		sorted_x[j] = t;
		t = sorted_y[i];
		sorted_y[i] = sorted_y[j];
		sorted_y[j] = t;
	endtask

	task automatic rasterize_step(input logic op, input coord_t ax, input coord_t ay,
			input coord_t bx, input coord_t by, input coord_t cx, input coord_t cy,
			output bit produced, output span_t span);
		longint one;
		bit     last;
		one = longint'(1) << FRAC_BITS;
		produced = 1'b0;
		span = '0;
		last = 1'b0;
		if (op == OP_LOAD) begin
			sorted_x[0] = longint'(ax);
			sorted_y[0] = longint'(ay);
			sorted_x[1] = longint'(bx);
			sorted_y[1] = longint'(by);
			sorted_x[2] = longint'(cx);
			sorted_y[2] = longint'(cy);
			if (sorted_y[0] > sorted_y[1]) swap_sorted(0, 1);
			if (sorted_y[1] > sorted_y[2]) swap_sorted(1, 2);
			if (sorted_y[0] > sorted_y[1]) swap_sorted(0, 1);
			short_step = edge_slope(sorted_x[1] - sorted_x[0], sorted_y[1] - sorted_y[0]);
			long_step = edge_slope(sorted_x[2] - sorted_x[0], sorted_y[2] - sorted_y[0]);
			start_acc = sorted_x[0] * one;
			end_acc = sorted_x[0] * one;
			scan_row = sorted_y[0];
			in_lower = 1'b0;
			busy = 1'b1;
			return;
		end
		if (!busy)
			return;
		produced = 1'b1;
		span.row = to_coord(scan_row);
		span.start_x = to_coord(start_acc / one);
		span.end_x = to_coord(end_acc / one);
		if (!in_lower) begin
			if (scan_row >= sorted_y[1]) begin
				in_lower = 1'b1;
				scan_row = sorted_y[1];
				if (sorted_y[2] - sorted_y[1] > 0)
					short_step = edge_slope(sorted_x[2] - sorted_x[1],
						sorted_y[2] - sorted_y[1]);
				long_step = edge_slope(sorted_x[2] - sorted_x[0], sorted_y[2] - sorted_y[0]);
				start_acc = sorted_x[1] * one;
				end_acc = sorted_x[0] * one + long_step * (sorted_y[1] - sorted_y[0]);
			end else begin
				scan_row++;
				start_acc += short_step;
				end_acc += long_step;
			end
		end else begin
			if (scan_row >= sorted_y[2]) begin
				last = 1'b1;
				busy = 1'b0;
			end else begin
				scan_row++;
				start_acc += short_step;
				end_acc += long_step;
			end
		end
		span.last = last;
	endtask

	// Called at a rising edge; returns at the edge where the item is taken.
	task automatic offer(input logic op, input coord_t ax, input coord_t ay,
			input coord_t bx, input coord_t by, input coord_t cx, input coord_t cy,
			input bit typed, input span_t want);
		int    gap;
		bit    produced;
		span_t predicted;
		gap = (idling_allowed() && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation <= op;
		vertex_a_x <= ax;
		vertex_a_y <= ay;
		vertex_b_x <= bx;
		vertex_b_y <= by;
		vertex_c_x <= cx;
		vertex_c_y <= cy;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		rasterize_step(op, ax, ay, bx, by, cx, cy, produced, predicted);
		if (produced)
			spans_due.push_back(typed ? want : predicted);
		if (op == OP_LOAD || produced)
			items_done++;
	endtask

	function automatic stim_row_t load_row(input int ax, input int ay, input int bx,
			input int by, input int cx, input int cy);
		stim_row_t r;
		r.op = OP_LOAD;
		r.ax = to_coord(longint'(ax));
		r.ay = to_coord(longint'(ay));
		r.bx = to_coord(longint'(bx));
		r.by = to_coord(longint'(by));
		r.cx = to_coord(longint'(cx));
		r.cy = to_coord(longint'(cy));
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t step_row(input bit typed, input int row, input int sx,
			input int ex, input bit last);
		stim_row_t r;
		r = load_row(0, 0, 0, 0, 0, 0);
		r.op = OP_SPAN;
		r.typed = typed;
		r.want.row = to_coord(longint'(row));
		r.want.start_x = to_coord(longint'(sx));
		r.want.end_x = to_coord(longint'(ex));
		r.want.last = last;
		return r;
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (spans_due.size() == 0) begin
				$display("%0t: unexpected span row %0d start %0d end %0d", $time,
					row_y, span_start_x, span_end_x);
				errors++;
			end else begin
				expected_span = spans_due.pop_front();
				compare_field("row_y", int'(expected_span.row), int'(row_y));
				compare_field("span_start_x", int'(expected_span.start_x), int'(span_start_x));
				compare_field("span_end_x", int'(expected_span.end_x), int'(span_end_x));
				compare_field("span_last", int'(expected_span.last), int'(span_last));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && items_done >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idling_allowed() && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(1, 19) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t dir_rows [$];
		int        h;
		int        ybase;
		int        ys [3];
		int        j;
		int        t;
		int        nsteps;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		dir_rows.push_back(step_row(1'b0, 0, 0, 0, 1'b0));
		dir_rows.push_back(load_row(-2048, 5, 2047, 5, 0, 5));
		dir_rows.push_back(step_row(1'b1, 5, -2048, -2048, 1'b0));
		dir_rows.push_back(step_row(1'b1, 5, 2047, -2048, 1'b1));
		dir_rows.push_back(step_row(1'b0, 0, 0, 0, 1'b0));
		dir_rows.push_back(load_row(0, 2045, -2048, 2047, 2047, 2046));
		repeat (4) dir_rows.push_back(step_row(1'b0, 0, 0, 0, 1'b0));
		dir_rows.push_back(load_row(2047, -2048, -2048, -2046, 100, -2047));
		repeat (4) dir_rows.push_back(step_row(1'b0, 0, 0, 0, 1'b0));
		dir_rows.push_back(load_row(-2048, -2048, 2047, 2047, 0, 0));
		repeat (2) dir_rows.push_back(step_row(1'b0, 0, 0, 0, 1'b0));
		dir_rows.push_back(load_row(-2048, 0, 2047, 0, 0, 2));
		repeat (4) dir_rows.push_back(step_row(1'b0, 0, 0, 0, 1'b0));

		foreach (dir_rows[i])
			offer(dir_rows[i].op, dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].bx,
				dir_rows[i].by, dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].typed,
				dir_rows[i].want);

		while (items_done < ITEM_GOAL) begin
			if ($urandom_range(0, 9) == 0) begin
				offer(rand_bit(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), 1'b0, '0);
			end else begin
				h = ($urandom_range(0, 29) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
				ybase = $urandom_range(0, 4095 - h) - 2048;
				ys[0] = ybase;
				ys[2] = ybase + h;
				case ($urandom_range(0, 5))
					0: ys[1] = ybase;
					1: ys[1] = ybase + h;
					default: ys[1] = ybase + $urandom_range(0, h);
				endcase
				for (int k = 2; k > 0; k--) begin
					j = $urandom_range(0, k);
					t = ys[k];
					ys[k] = ys[j];
					ys[j] = t;
				end
				offer(OP_LOAD, rand_coord(), to_coord(longint'(ys[0])), rand_coord(),
					to_coord(longint'(ys[1])), rand_coord(), to_coord(longint'(ys[2])), 1'b0, '0);
				nsteps = h + 2;
				if ($urandom_range(0, 9) == 0)
					nsteps = $urandom_range(0, h + 1);
				else if ($urandom_range(0, 4) == 0)
					nsteps += $urandom_range(1, 2);
				repeat (nsteps)
					offer(OP_SPAN, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
						rand_coord(), rand_coord(), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		while (spans_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
